### rtl/blg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blg_pkg: battery level gauge shared types and constants
// Field widths, converter and voltage constants, and the sequencer states.
// ----------------------------------------------------------------------------
package blg_pkg;

   // Field widths
   localparam int SAMPLE_W    = 12;
   localparam int CF_W        = 16;
   localparam int CF_FRAC     = 14;
   localparam int SUM_W       = 16;
   localparam int PIN_W       = 12;
   localparam int MV_W        = 14;
   localparam int LEVEL_W     = 7;
   localparam int PROD_W      = SUM_W + PIN_W;
   localparam int LVL_SPAN_W  = 10;

   // Divider: numerator, divisor and step counter widths
   localparam int DIV_W       = PROD_W;
   localparam int DEN_W       = 16;
   localparam int DCNT_W      = $clog2(DIV_W + 1);

   // Converter and voltage constants
   localparam int                ADC_FULL      = 4095;
   localparam logic [PIN_W-1:0]  PIN_FULL_MV   = 12'd3300;
   localparam logic [MV_W-1:0]   LEVEL_LOW_MV  = 14'd3200;
   localparam logic [MV_W-1:0]   LEVEL_HIGH_MV = 14'd4200;
   localparam int                LEVEL_STEP_MV = 10;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 7'd100;
   localparam logic [CF_W-1:0]   CF_RESET      = 16'd16384;

   // Divide by the level step as multiply and shift; exact for spans below 1024
   localparam int LEVEL_SHIFT   = 11;
   localparam int LEVEL_RECIP_W = 8;
   localparam logic [LEVEL_RECIP_W-1:0] LEVEL_RECIP =
      LEVEL_RECIP_W'((2 ** LEVEL_SHIFT + LEVEL_STEP_MV - 1) / LEVEL_STEP_MV);
   localparam int LVL_PROD_W    = LVL_SPAN_W + LEVEL_RECIP_W;

   // Sequencer states
   typedef enum logic [6:0] {
      ST_IDLE    = 7'b000_0001,
      ST_SCALE   = 7'b000_0010,
      ST_BATT    = 7'b000_0100,
      ST_PUSH    = 7'b000_1000,
      ST_SUM     = 7'b001_0000,
      ST_AVG_DIV = 7'b010_0000,
      ST_LEVEL   = 7'b100_0000
   } state_type;

endpackage
`default_nettype wire

### rtl/blg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module blg_ram #(
   parameter int DATA_W = 14,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/battery_level_gauge.sv
`default_nettype none
// Inside a group the input takes one sample per cycle and stays ready. A sample that closes a
// group holds the input off while the sequencer scales the sum, applies the correction, pushes
// into the ring, reads and sums the filled ring entries, divides for the average, maps the
// level and hands the result over, which waits while the previous result is not taken. Reset
// (synchronous, active high) clears group sum, ring pointer and fill, sets the factor to one;
// ring contents stay.
// ----------------------------------------------------------------------------
// battery_level_gauge: battery voltage and charge level estimator
// Sums groups of converter samples, scales to millivolts, corrects, averages
// a ring of recent voltages and maps the average to a 0..100 percent level.
// ----------------------------------------------------------------------------
module battery_level_gauge #(
   parameter int RING_DEPTH          = 8,
   parameter int SAMPLES_PER_MEASURE = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [blg_pkg::SAMPLE_W-1:0]   req_adc_sample,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [blg_pkg::LEVEL_W-1:0]    rsp_level_percent,
   output logic      [blg_pkg::MV_W-1:0]       rsp_average_mv,
   output logic      [blg_pkg::MV_W-1:0]       rsp_battery_mv,
   output logic      [blg_pkg::PIN_W-1:0]      rsp_pin_mv,
   output logic                                rsp_overflow,
   // configuration
   input  wire logic                           csr_wr_en,
   input  wire logic [blg_pkg::CF_W-1:0]       csr_wr_data
);

   import blg_pkg::*;

   localparam int CNT_W  = (SAMPLES_PER_MEASURE > 1) ? $clog2(SAMPLES_PER_MEASURE) : 1;
   localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int ACC_W  = MV_W + FILL_W;

   // Pin scaling as multiply and shift; the shift of twice the full-sum width keeps
   // the truncated quotient exact for every sum up to full scale
   localparam int     FULL_SUM_I  = ADC_FULL * SAMPLES_PER_MEASURE;
   localparam int     PIN_SHIFT   = 2 * $clog2(FULL_SUM_I + 1);
   localparam longint PIN_RECIP_L = ((longint'(PIN_FULL_MV) << PIN_SHIFT)
                                     + longint'(FULL_SUM_I) - 1) / longint'(FULL_SUM_I);
   localparam int     PIN_RECIP_W = $clog2(PIN_RECIP_L + 1);
   localparam int     PIN_PROD_W  = SUM_W + PIN_RECIP_W;

   localparam logic [CNT_W-1:0]       LAST_CNT  = CNT_W'(SAMPLES_PER_MEASURE - 1);
   localparam logic [PTR_W-1:0]       LAST_PTR  = PTR_W'(RING_DEPTH - 1);
   localparam logic [FILL_W-1:0]      FULL_FILL = FILL_W'(RING_DEPTH);
   localparam logic [SUM_W-1:0]       FULL_SUM  = SUM_W'(FULL_SUM_I);
   localparam logic [PIN_RECIP_W-1:0] PIN_RECIP = PIN_RECIP_W'(PIN_RECIP_L);

   // Control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [CF_W-1:0]     cf_ff, cf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DCNT_W-1:0]   div_cnt_ff, div_cnt_in;

   // Working payload
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [DIV_W-1:0]    div_num_ff, div_num_in;
   logic [DEN_W-1:0]    div_rem_ff, div_rem_in;
   logic [DEN_W-1:0]    div_den_ff, div_den_in;
   logic [PIN_W-1:0]    pin_ff, pin_in;
   logic [MV_W-1:0]     batt_ff, batt_in;
   logic [MV_W-1:0]     avg_ff, avg_in;
   logic                ovf_ff, ovf_in;

   // Result register
   logic [LEVEL_W-1:0]  out_level_ff, out_level_in;
   logic [MV_W-1:0]     out_avg_ff, out_avg_in;
   logic [MV_W-1:0]     out_batt_ff, out_batt_in;
   logic [PIN_W-1:0]    out_pin_ff, out_pin_in;
   logic                out_ovf_ff, out_ovf_in;

   // Datapath nets
   logic                req_beat;
   logic [DEN_W:0]      div_trial;
   logic [DEN_W:0]      div_diff;
   logic                div_ge;
   logic [PIN_PROD_W-1:0] pin_prod;
   logic [PROD_W-1:0]   batt_prod;
   logic [MV_W-1:0]     avg_q;
   logic [MV_W-1:0]     avg_clamped;
   logic [LVL_SPAN_W-1:0] lvl_span;
   logic [LVL_PROD_W-1:0] lvl_prod;
   logic                ram_wr_en;
   logic [MV_W-1:0]     ram_rd_data;

   // Ring of recent battery voltages
   blg_ram #(
      .DATA_W (MV_W),
      .DEPTH  (RING_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (batt_ff),
      .rd_addr (idx_ff[PTR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign ram_wr_en = (state_ff == ST_PUSH);

   // Restoring divider step for the average: one quotient bit per cycle
   assign div_trial = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign div_diff  = div_trial - {1'b0, div_den_ff};
   assign div_ge    = (div_trial >= {1'b0, div_den_ff});

   // Group sum to pin millivolts, and correction product
   assign pin_prod  = PIN_PROD_W'(sum_ff) * PIN_PROD_W'(PIN_RECIP);
   assign batt_prod = PROD_W'(pin_ff) * PROD_W'(cf_ff);

   // Clamp the finished average into the level window and scale to percent
   assign avg_q = div_num_ff[MV_W-1:0];
   always_comb begin
      if (avg_ff < LEVEL_LOW_MV) begin
         avg_clamped = LEVEL_LOW_MV;
      end else if (avg_ff > LEVEL_HIGH_MV) begin
         avg_clamped = LEVEL_HIGH_MV;
      end else begin
         avg_clamped = avg_ff;
      end
   end
   assign lvl_span = LVL_SPAN_W'(avg_clamped - LEVEL_LOW_MV);
   assign lvl_prod = LVL_PROD_W'(lvl_span) * LVL_PROD_W'(LEVEL_RECIP);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      cf_in        = cf_ff;
      rsp_valid_in = rsp_valid_ff;
      div_cnt_in   = div_cnt_ff;
      acc_in       = acc_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      pin_in       = pin_ff;
      batt_in      = batt_ff;
      avg_in       = avg_ff;
      ovf_in       = ovf_ff;
      out_level_in = out_level_ff;
      out_avg_in   = out_avg_ff;
      out_batt_in  = out_batt_ff;
      out_pin_in   = out_pin_ff;
      out_ovf_in   = out_ovf_ff;

      // write the correction factor
      if (csr_wr_en) begin
         cf_in = csr_wr_data;
      end

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // accumulate one sample; close the group on the last one
            if (req_beat) begin
               sum_in = sum_ff + SUM_W'(req_adc_sample);
               if (cnt_ff == LAST_CNT) begin
                  cnt_in   = '0;
                  state_in = ST_SCALE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         ST_SCALE: begin
            // sum * 3300 / full-scale sum, by reciprocal multiply
            ovf_in   = (sum_ff == FULL_SUM);
            pin_in   = pin_prod[PIN_SHIFT +: PIN_W];
            sum_in   = '0;
            state_in = ST_BATT;
         end

         ST_BATT: begin
            // apply the Q2.14 correction
            batt_in  = batt_prod[PROD_W-1:CF_FRAC];
            state_in = ST_PUSH;
         end

         ST_PUSH: begin
            // push into the ring and advance pointer and fill
            ptr_in = (ptr_ff == LAST_PTR) ? '0 : ptr_ff + 1'b1;
            if (fill_ff != FULL_FILL) begin
               fill_in = fill_ff + 1'b1;
            end
            acc_in   = '0;
            idx_in   = '0;
            state_in = ST_SUM;
         end

         ST_SUM: begin
            // read filled entries one per cycle, add each one in the cycle after its read
            if (idx_ff < fill_ff) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               acc_in = acc_ff + ACC_W'(ram_rd_data);
            end
            if (idx_ff == fill_ff && !pend_ff) begin
               div_num_in = DIV_W'(acc_ff) << (DIV_W - ACC_W);
               div_rem_in = '0;
               div_den_in = DEN_W'(fill_ff);
               div_cnt_in = DCNT_W'(ACC_W);
               state_in   = ST_AVG_DIV;
            end
         end

         ST_AVG_DIV: begin
            if (div_cnt_ff != '0) begin
               div_num_in = {div_num_ff[DIV_W-2:0], div_ge};
               div_rem_in = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
               div_cnt_in = div_cnt_ff - 1'b1;
            end else begin
               avg_in   = avg_q;
               state_in = ST_LEVEL;
            end
         end

         ST_LEVEL: begin
            // hold until the output register is free, then hand the result over
            if (!rsp_valid_ff || rsp_ready) begin
               out_level_in = lvl_prod[LEVEL_SHIFT +: LEVEL_W];
               out_avg_in   = avg_ff;
               out_batt_in  = batt_ff;
               out_pin_in   = pin_ff;
               out_ovf_in   = ovf_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         cf_ff        <= CF_RESET;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cf_ff        <= cf_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      pin_ff       <= pin_in;
      batt_ff      <= batt_in;
      avg_ff       <= avg_in;
      ovf_ff       <= ovf_in;
      out_level_ff <= out_level_in;
      out_avg_ff   <= out_avg_in;
      out_batt_ff  <= out_batt_in;
      out_pin_ff   <= out_pin_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_percent = out_level_ff;
   assign rsp_average_mv    = out_avg_ff;
   assign rsp_battery_mv    = out_batt_ff;
   assign rsp_pin_mv        = out_pin_ff;
   assign rsp_overflow      = out_ovf_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("ring fill beyond depth");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level_percent <= LEVEL_MAX)
      else $error("level above 100 percent");

   a_level_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_average_mv >= LEVEL_HIGH_MV |-> rsp_level_percent == LEVEL_MAX)
      else $error("level not full at high average");

   a_ovf_pin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_pin_mv == PIN_FULL_MV)
      else $error("overflow without full-scale pin voltage");

   a_sum_read_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> idx_ff <= fill_ff)
      else $error("ring read past fill");

endmodule
`default_nettype wire

### tb/sv/battery_level_gauge_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_level_gauge_test: self-checking testbench for the battery gauge
// Streams converter samples through the request channel with random gaps,
// back-pressures the result channel at random, and checks every reading
// against an in-bench model of the group sum, scaling, correction, voltage
// ring average and level mapping. The correction factor changes between
// phases, sometimes with a group half taken.
// ----------------------------------------------------------------------------
module battery_level_gauge_test;
   import blg_pkg::*;

   localparam int GROUP_LEN     = 10;
   localparam int RING_LEN      = 8;
   localparam int PHASES        = 9;
   localparam int SETTLE_CYCLES = 100;
   localparam int IDLE_LIMIT    = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int MAX_WAIT      = 10;

   typedef struct {
      logic [LEVEL_W-1:0] level_percent;
      logic [MV_W-1:0]    average_mv;
      logic [MV_W-1:0]    battery_mv;
      logic [PIN_W-1:0]   pin_mv;
      logic               overflow;
   } gauge_reading_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_adc_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]  rsp_level_percent;
   logic [MV_W-1:0]     rsp_average_mv;
   logic [MV_W-1:0]     rsp_battery_mv;
   logic [PIN_W-1:0]    rsp_pin_mv;
   logic                rsp_overflow;
   logic                csr_wr_en = 1'b0;
   logic [CF_W-1:0]     csr_wr_data = '0;

   // Model state of the gauge
   logic [CF_W-1:0]     correction;
   logic [SUM_W-1:0]    group_sum;
   int unsigned         group_taken;
   logic [MV_W-1:0]     voltage_hist [RING_LEN];
   int unsigned         hist_wr_ptr;
   int unsigned         hist_fill;

   logic [SAMPLE_W-1:0] adc_backlog [$];
   gauge_reading_type   expected_readings [$];
   gauge_reading_type   new_reading;
   gauge_reading_type   want;

   int unsigned         mismatch_count = 0;
   int unsigned         rsp_beats = 0;
   int unsigned         req_gap = 0;
   int unsigned         rsp_stall = 0;
   int unsigned         idle_cycles = 0;
   bit                  req_no_idle = 1'b0;
   bit                  rsp_no_idle = 1'b0;
   bit                  req_busy;

   battery_level_gauge #(
      .RING_DEPTH          (RING_LEN),
      .SAMPLES_PER_MEASURE (GROUP_LEN)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level_percent (rsp_level_percent),
      .rsp_average_mv    (rsp_average_mv),
      .rsp_battery_mv    (rsp_battery_mv),
      .rsp_pin_mv        (rsp_pin_mv),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Take one sample; return 1 with the reading when it closes a group
   function automatic bit gauge_take_sample(input logic [SAMPLE_W-1:0] sample,
                                            output gauge_reading_type reading);
      int unsigned full_sum;
      int unsigned pin;
      int unsigned batt;
      int unsigned acc;
      int unsigned avg;
      int unsigned clamped;
      full_sum    = ADC_FULL * GROUP_LEN;
      group_sum   = group_sum + SUM_W'(sample);
      group_taken = group_taken + 1;
      reading     = '{default: '0};
      if (group_taken < GROUP_LEN) begin
         return 1'b0;
      end

      // Scale the group sum to pin millivolts, then apply the divider correction
      pin = (int'(group_sum) * int'(PIN_FULL_MV)) / full_sum;
      if (pin > PIN_FULL_MV) begin
         pin = PIN_FULL_MV;
      end
      batt = (pin * int'(correction)) >> CF_FRAC;

      // Push into the history ring and average the filled entries
      voltage_hist[hist_wr_ptr] = MV_W'(batt);
      hist_wr_ptr = (hist_wr_ptr + 1) % RING_LEN;
      if (hist_fill < RING_LEN) begin
         hist_fill = hist_fill + 1;
      end
      acc = 0;
      for (int i = 0; i < hist_fill; i++) begin
         acc = acc + voltage_hist[i];
      end
      avg = acc / hist_fill;

      // Clamp to the usable window and map linearly to percent
      clamped = avg;
      if (clamped < LEVEL_LOW_MV) begin
         clamped = LEVEL_LOW_MV;
      end else if (clamped > LEVEL_HIGH_MV) begin
         clamped = LEVEL_HIGH_MV;
      end
      reading.level_percent = LEVEL_W'(((clamped - LEVEL_LOW_MV) * LEVEL_MAX)
                                       / (LEVEL_HIGH_MV - LEVEL_LOW_MV));
      reading.average_mv    = MV_W'(avg);
      reading.battery_mv    = MV_W'(batt);
      reading.pin_mv        = PIN_W'(pin);
      reading.overflow      = (int'(group_sum) == full_sum);
      group_sum   = '0;
      group_taken = 0;
      return 1'b1;
   endfunction

   // Drive request beats from the backlog, with a random gap before each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         req_busy = req_valid;
         if (req_valid && req_ready) begin
            if (gauge_take_sample(req_adc_sample, new_reading)) begin
               expected_readings.push_back(new_reading);
            end
            req_busy = 1'b0;
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (adc_backlog.size() > 0) begin
               req_adc_sample <= adc_backlog.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 29) == 0) begin
                  req_no_idle = !req_no_idle;
               end
               req_gap = req_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Accept and check result beats; hold ready low for a random stall per beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats = rsp_beats + 1;
            if (expected_readings.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("result beat %0d with no reading expected: level %0d avg %0d",
                           rsp_beats, rsp_level_percent, rsp_average_mv);
               end
            end else begin
               want = expected_readings.pop_front();
               if (want.level_percent !== rsp_level_percent ||
                   want.average_mv !== rsp_average_mv ||
                   want.battery_mv !== rsp_battery_mv ||
                   want.pin_mv !== rsp_pin_mv ||
                   want.overflow !== rsp_overflow) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("reading %0d: expected level %0d avg %0d batt %0d pin %0d ovf %0d, ",
                            rsp_beats, want.level_percent, want.average_mv,
                            want.battery_mv, want.pin_mv, want.overflow);
                     $display("got level %0d avg %0d batt %0d pin %0d ovf %0d",
                              rsp_level_percent, rsp_average_mv, rsp_battery_mv,
                              rsp_pin_mv, rsp_overflow);
                  end
               end
            end
            if ($urandom_range(0, 29) == 0) begin
               rsp_no_idle = !rsp_no_idle;
            end
            rsp_stall = rsp_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (rsp_valid && rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // Abort when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("battery_level_gauge: mismatch");
            $finish;
         end
      end
   end

   // Sequence the phases: drain, reprogram the factor, queue the next samples
   initial begin
      int unsigned          remaining;
      int unsigned          base;
      int                   jittered;
      bit                   uniform;
      logic [CF_W-1:0]      factor;
      correction  = CF_RESET;
      group_sum   = '0;
      group_taken = 0;
      hist_wr_ptr = 0;
      hist_fill   = 0;
      foreach (voltage_hist[i]) begin
         voltage_hist[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; ; phase++) begin
         // Wait for all beats and readings, then let the block go quiet
         do @(negedge clock);
         while (adc_backlog.size() != 0 || req_valid || expected_readings.size() != 0);
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (phase == PHASES) begin
            break;
         end

         case (phase)
            0, 3:    factor = '1;
            1:       factor = '0;
            2:       factor = CF_RESET;
            4:       factor = 16'd1;
            8:       factor = CF_W'($urandom_range(0, 65535));
            default: factor = CF_W'($urandom_range(19000, 27000));
         endcase
         csr_wr_en   <= 1'b1;
         csr_wr_data <= factor;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         correction = factor;

         if (phase == 0) begin
            // Full-scale group (overflow, largest voltage), empty group, bit patterns
            repeat (GROUP_LEN) adc_backlog.push_back('1);
            repeat (GROUP_LEN) adc_backlog.push_back('0);
            adc_backlog.push_back(12'hAAA);
            adc_backlog.push_back(12'h555);
            adc_backlog.push_back(12'h800);
         end else begin
            // Mostly tight groups around one level, some fully random groups;
            // the phase length cuts a group at a random point
            remaining = $urandom_range(200, 280);
            while (remaining > 0) begin
               uniform = ($urandom_range(0, 9) < 3);
               base = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(3000, 4095);
               for (int k = 0; k < GROUP_LEN && remaining > 0; k++) begin
                  jittered = int'(base) + int'($urandom_range(0, 128)) - 64;
                  if (jittered < 0) begin
                     jittered = 0;
                  end else if (jittered > ADC_FULL) begin
                     jittered = ADC_FULL;
                  end
                  adc_backlog.push_back(uniform ? SAMPLE_W'($urandom_range(0, 4095))
                                                : SAMPLE_W'(jittered));
                  remaining = remaining - 1;
               end
            end
         end
      end

      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("battery_level_gauge: match");
      end else begin
         $display("battery_level_gauge: mismatch");
      end
      $finish;
   end

endmodule
